/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the blur unit. Each one samples
// on the rising edge of clk and is switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EXB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EXB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/exb2d_pkg.sv */
// ----------------------------------------------------------------------------
// exb2d_pkg
// Request codes, register indexes, fixed widths and the controller to
// datapath command bundle of the exponential blur unit.
// ----------------------------------------------------------------------------
`default_nettype none

package exb2d_pkg;

    localparam int PIX_W     = 8;
    localparam int ALPHA_W   = 16;
    localparam int ACC_W     = 16;
    localparam int CFG_DIM_W = 9;
    localparam int IDX_W     = 8;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_BLUR  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    localparam logic [CFG_DIM_W-1:0] DIM_RESET = 9'd256;

    typedef struct packed {
        logic host_wr;    // host pixel write this cycle
        logic host_rd;    // host pixel read this cycle
        logic blur_start; // a blur request was taken
        logic blur_rd;    // fetch the pixel under the filter
        logic mul_en;     // register alpha times the difference
        logic acc_clr;    // start a new sweep with a zero accumulator
        logic acc_wr;     // update accumulator and store the filtered pixel
        logic zero_wr;    // store zero at either end of the line
        logic col_phase;  // lines are columns
    } dp_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/exb2d_cfg.sv */
// ----------------------------------------------------------------------------
// exb2d_cfg
// APB register file: filter coefficient, enable and active region size.
// ----------------------------------------------------------------------------
`default_nettype none

module exb2d_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [exb2d_pkg::APB_AW-1:0]    paddr,
    input  wire logic [exb2d_pkg::APB_DW-1:0]    pwdata,
    output logic      [exb2d_pkg::APB_DW-1:0]    prdata,
    output logic      [exb2d_pkg::ALPHA_W-1:0]   blur_alpha,
    output logic                                 blur_enable,
    output logic      [exb2d_pkg::CFG_DIM_W-1:0] image_width,
    output logic      [exb2d_pkg::CFG_DIM_W-1:0] image_height
);
    import exb2d_pkg::*;

    logic [ALPHA_W-1:0]   alpha_reg;
    logic                 enable_reg;
    logic [CFG_DIM_W-1:0] width_reg;
    logic [CFG_DIM_W-1:0] height_reg;
    logic                 wr_en;
    logic [1:0]           reg_idx;

    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= '0;
            enable_reg <= 1'b0;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ALPHA:  alpha_reg  <= pwdata[ALPHA_W-1:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[CFG_DIM_W-1:0];
                default:    alpha_reg  <= alpha_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ALPHA:  prdata = {{(APB_DW-ALPHA_W){1'b0}}, alpha_reg};
            REG_ENABLE: prdata = {{(APB_DW-1){1'b0}}, enable_reg};
            REG_WIDTH:  prdata = {{(APB_DW-CFG_DIM_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(APB_DW-CFG_DIM_W){1'b0}}, height_reg};
            default:    prdata = '0;
        endcase
    end

    assign blur_alpha   = alpha_reg;
    assign blur_enable  = enable_reg;
    assign image_width  = width_reg;
    assign image_height = height_reg;

endmodule

`default_nettype wire

/* hw/rtl/exb2d_ctrl.sv */
// ----------------------------------------------------------------------------
// exb2d_ctrl
// Request decode and the blur sequencer: walks rows then columns, two passes
// per line, each pass a forward and a backward sweep with end zeroing.
// ----------------------------------------------------------------------------
`default_nettype none

module exb2d_ctrl #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DIM_CW     = 9
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [1:0]                      req_type,
    input  wire logic                            blur_enable,
    input  wire logic [exb2d_pkg::CFG_DIM_W-1:0] image_width,
    input  wire logic [exb2d_pkg::CFG_DIM_W-1:0] image_height,
    output logic                                 busy,
    output logic                                 result_valid,
    output logic                                 blur_done,
    output exb2d_pkg::dp_cmd_t                   cmd,
    output logic      [DIM_CW-1:0]               line,
    output logic      [DIM_CW-1:0]               pos
);
    import exb2d_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_LINE,
        S_F_RD,
        S_F_MUL,
        S_F_ACC,
        S_ZERO_LAST,
        S_B_RD,
        S_B_MUL,
        S_B_ACC,
        S_ZERO_FIRST,
        S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic              pass_reg, pass_next;
    logic              phase_reg, phase_next;
    logic [DIM_CW-1:0] line_reg, line_next;
    logic [DIM_CW-1:0] k_reg, k_next;
    logic              valid_reg, valid_next;
    logic              done_reg, done_next;

    logic [DIM_CW-1:0] w_eff, h_eff, n_len, n_lines;
    logic [DIM_CW-1:0] k_inc, k_dec, n_last, line_inc;
    logic              take;

    assign w_eff = (DIM_CW'(image_width) > DIM_CW'(MAX_WIDTH)) ?
                   DIM_CW'(MAX_WIDTH) : DIM_CW'(image_width);
    assign h_eff = (DIM_CW'(image_height) > DIM_CW'(MAX_HEIGHT)) ?
                   DIM_CW'(MAX_HEIGHT) : DIM_CW'(image_height);

    // Row phase: lines are rows of w_eff pixels; column phase the reverse.
    assign n_len    = phase_reg ? h_eff : w_eff;
    assign n_lines  = phase_reg ? w_eff : h_eff;
    assign k_inc    = k_reg + DIM_CW'(1);
    assign k_dec    = k_reg - DIM_CW'(1);
    assign n_last   = n_len - DIM_CW'(1);
    assign line_inc = line_reg + DIM_CW'(1);

    assign busy = (state_reg != S_IDLE);
    assign take = start & ~busy;

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        phase_next = phase_reg;
        line_next  = line_reg;
        k_next     = k_reg;
        valid_next = 1'b0;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.col_phase = phase_reg;
        pos        = k_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    case (req_type)
                        REQ_WRITE:
                        begin
                            cmd.host_wr = 1'b1;
                        end
                        REQ_READ:
                        begin
                            cmd.host_rd = 1'b1;
                            valid_next  = 1'b1;
                        end
                        REQ_BLUR:
                        begin
                            cmd.blur_start = 1'b1;
                            state_next     = S_SETUP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                phase_next = 1'b0;
                pass_next  = 1'b0;
                line_next  = '0;
                if (!blur_enable || w_eff == '0 || h_eff == '0)
                    state_next = S_FINISH;
                else
                    state_next = S_LINE;
            end
            S_LINE:
            begin
                cmd.acc_clr = 1'b1;
                k_next      = DIM_CW'(1);
                state_next  = (n_len > DIM_CW'(1)) ? S_F_RD : S_ZERO_LAST;
            end
            S_F_RD:
            begin
                cmd.blur_rd = 1'b1;
                state_next  = S_F_MUL;
            end
            S_F_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_F_ACC;
            end
            S_F_ACC:
            begin
                cmd.acc_wr = 1'b1;
                k_next     = k_inc;
                state_next = (k_inc == n_len) ? S_ZERO_LAST : S_F_RD;
            end
            S_ZERO_LAST:
            begin
                pos         = n_last;
                cmd.zero_wr = 1'b1;
                cmd.acc_clr = 1'b1;
                k_next      = n_last;
                state_next  = (n_last != '0) ? S_B_RD : S_ZERO_FIRST;
            end
            S_B_RD:
            begin
                pos         = k_dec;
                cmd.blur_rd = 1'b1;
                state_next  = S_B_MUL;
            end
            S_B_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_B_ACC;
            end
            S_B_ACC:
            begin
                pos        = k_dec;
                cmd.acc_wr = 1'b1;
                k_next     = k_dec;
                state_next = (k_dec == '0) ? S_ZERO_FIRST : S_B_RD;
            end
            S_ZERO_FIRST:
            begin
                pos         = '0;
                cmd.zero_wr = 1'b1;
                state_next  = S_LINE;
                if (!pass_reg)
                begin
                    pass_next = 1'b1;
                end
                else
                begin
                    pass_next = 1'b0;
                    if (line_inc == n_lines)
                    begin
                        line_next = '0;
                        if (!phase_reg)
                            phase_next = 1'b1;
                        else
                            state_next = S_FINISH;
                    end
                    else
                    begin
                        line_next = line_inc;
                    end
                end
            end
            S_FINISH:
            begin
                valid_next = 1'b1;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= 1'b0;
            phase_reg <= 1'b0;
            line_reg  <= '0;
            k_reg     <= '0;
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            phase_reg <= phase_next;
            line_reg  <= line_next;
            k_reg     <= k_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
        end
    end

    assign line         = line_reg;
    assign result_valid = valid_reg;
    assign blur_done    = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/exb2d_datapath.sv */
// ----------------------------------------------------------------------------
// exb2d_datapath
// Image memory, address generation and the one-pole filter arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module exb2d_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int DIM_CW     = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire exb2d_pkg::dp_cmd_t            cmd,
    input  wire logic [DIM_CW-1:0]             line,
    input  wire logic [DIM_CW-1:0]             pos,
    input  wire logic [exb2d_pkg::IDX_W-1:0]   col_index,
    input  wire logic [exb2d_pkg::IDX_W-1:0]   row_index,
    input  wire logic [exb2d_pkg::PIX_W-1:0]   pixel_in,
    input  wire logic [exb2d_pkg::ALPHA_W-1:0] blur_alpha,
    output logic      [exb2d_pkg::PIX_W-1:0]   pixel_out
);
    import exb2d_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int DIFF_W = ACC_W + 1;
    localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
    localparam int STEP_W = PROD_W - 16;

    logic [PIX_W-1:0] image_mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;
    logic [ACC_W-1:0] acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic             sel_reg;

    logic                     in_store;
    logic [AW-1:0]            host_addr, blur_addr, wr_addr, rd_addr;
    logic                     mem_we, mem_re;
    logic [PIX_W-1:0]         wdata;
    logic signed [DIFF_W-1:0] diff;
    logic signed [STEP_W-1:0] acc_sum;
    logic [ACC_W-1:0]         acc_next;

    assign in_store = (DIM_CW'(col_index) < DIM_CW'(MAX_WIDTH)) &&
                      (DIM_CW'(row_index) < DIM_CW'(MAX_HEIGHT));

    assign host_addr = AW'(row_index) * AW'(MAX_WIDTH) + AW'(col_index);
    assign blur_addr = cmd.col_phase ? (AW'(pos) * AW'(MAX_WIDTH) + AW'(line))
                                     : (AW'(line) * AW'(MAX_WIDTH) + AW'(pos));

    // Difference between the scaled pixel and the running accumulator.
    assign diff = $signed({2'b00, rdata_reg, 7'b0000000}) - $signed({1'b0, acc_reg});

    // Arithmetic shift of the product gives the floor of the Q16 step.
    assign acc_sum  = $signed({{(STEP_W-ACC_W){1'b0}}, acc_reg}) + prod_reg[PROD_W-1:16];
    assign acc_next = acc_sum[ACC_W-1:0];

    assign mem_we  = (cmd.host_wr & in_store) | cmd.acc_wr | cmd.zero_wr;
    assign mem_re  = (cmd.host_rd & in_store) | cmd.blur_rd;
    assign wr_addr = cmd.host_wr ? host_addr : blur_addr;
    assign rd_addr = cmd.host_rd ? host_addr : blur_addr;

    always_comb
    begin
        if (cmd.host_wr)
            wdata = pixel_in;
        else if (cmd.zero_wr)
            wdata = '0;
        else
            wdata = acc_next[PIX_W+6:7];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            image_mem[wr_addr] <= wdata;
        if (mem_re)
            rdata_reg <= image_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= $signed({1'b0, blur_alpha}) * diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            sel_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_clr)
                acc_reg <= '0;
            else if (cmd.acc_wr)
                acc_reg <= acc_next;

            if (cmd.host_rd)
                sel_reg <= in_store;
            else if (cmd.blur_start)
                sel_reg <= 1'b0;
        end
    end

    assign pixel_out = sel_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

/* hw/rtl/exponential_blur_2d_unit.sv */
// ----------------------------------------------------------------------------
// exponential_blur_2d_unit
// Grayscale image store with a two-dimensional recursive exponential blur.
//
//   Channel   Handshake                 Payload
//   request   start / busy              req_type, col_index, row_index, pixel_in
//   result    result_valid (strobe)     pixel_out, blur_done
//   config    APB psel/penable/pready   paddr, pwdata, prdata
//
// A pixel write or read is taken at once and busy stays low, so requests
// may follow back to back; a read result shows in the next cycle.
// A blur holds busy until its result, also when disabled or empty; its length
// is set by the single-port-read image memory and the read, multiply,
// accumulate step per pixel.
// Reset clears control state and the configuration registers; image contents are not cleared.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module exponential_blur_2d_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    req_type,
    input  wire logic [exb2d_pkg::IDX_W-1:0]   col_index,
    input  wire logic [exb2d_pkg::IDX_W-1:0]   row_index,
    input  wire logic [exb2d_pkg::PIX_W-1:0]   pixel_in,
    output logic                               result_valid,
    output logic      [exb2d_pkg::PIX_W-1:0]   pixel_out,
    output logic                               blur_done,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [exb2d_pkg::APB_AW-1:0]  paddr,
    input  wire logic [exb2d_pkg::APB_DW-1:0]  pwdata,
    output logic      [exb2d_pkg::APB_DW-1:0]  prdata,
    output logic                               pready
);
    import exb2d_pkg::*;

    localparam int WCW    = $clog2(MAX_WIDTH + 1);
    localparam int HCW    = $clog2(MAX_HEIGHT + 1);
    localparam int MCW    = (WCW > HCW) ? WCW : HCW;
    localparam int DIM_CW = (MCW > CFG_DIM_W) ? MCW : CFG_DIM_W;

    logic [ALPHA_W-1:0]   blur_alpha;
    logic                 blur_enable;
    logic [CFG_DIM_W-1:0] image_width;
    logic [CFG_DIM_W-1:0] image_height;
    dp_cmd_t              cmd;
    logic [DIM_CW-1:0]    line;
    logic [DIM_CW-1:0]    pos;

    assign pready = 1'b1;

    exb2d_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .blur_alpha   (blur_alpha),
        .blur_enable  (blur_enable),
        .image_width  (image_width),
        .image_height (image_height)
    );

    exb2d_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DIM_CW     (DIM_CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .req_type     (req_type),
        .blur_enable  (blur_enable),
        .image_width  (image_width),
        .image_height (image_height),
        .busy         (busy),
        .result_valid (result_valid),
        .blur_done    (blur_done),
        .cmd          (cmd),
        .line         (line),
        .pos          (pos)
    );

    exb2d_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DIM_CW     (DIM_CW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .line       (line),
        .pos        (pos),
        .col_index  (col_index),
        .row_index  (row_index),
        .pixel_in   (pixel_in),
        .blur_alpha (blur_alpha),
        .pixel_out  (pixel_out)
    );

endmodule

`default_nettype wire

/* hw/rtl/exb2d_checker.sv */
// ----------------------------------------------------------------------------
// exb2d_checker
// Port-level checks of request, busy and result timing, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module exb2d_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic [1:0]                  req_type,
    input wire logic                        result_valid,
    input wire logic [exb2d_pkg::PIX_W-1:0] pixel_out,
    input wire logic                        blur_done
);
    import exb2d_pkg::*;

    logic take;

    assign take = start & ~busy;

    `EXB_ASSERT_NEXT(a_read_answers, take && req_type == REQ_READ, result_valid && !blur_done, "read request did not give a pixel result in the next cycle")
    `EXB_ASSERT_NEXT(a_write_silent, take && req_type == REQ_WRITE, !result_valid, "write request gave a result")
    `EXB_ASSERT_NEXT(a_blur_busy, take && req_type == REQ_BLUR, busy, "blur request did not raise busy")
    `EXB_ASSERT_SAME(a_blur_end, $fell(busy), result_valid && blur_done, "busy fell without a blur done result")
    `EXB_ASSERT_SAME(a_done_zero, result_valid && blur_done, pixel_out == '0, "blur result carries a nonzero pixel")

endmodule

bind exponential_blur_2d_unit exb2d_checker u_exb2d_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .result_valid (result_valid),
    .pixel_out    (pixel_out),
    .blur_done    (blur_done)
);

`default_nettype wire

/* dv/tb_exponential_blur_2d_unit.sv */
// ----------------------------------------------------------------------------
// tb_exponential_blur_2d_unit
// Self-checking bench for the blur unit. Pixel writes, reads and blur requests
// go in through start/busy, and the register file is set through APB between
// phases. A local copy of the image store runs the fixed-point two-pass
// row/column filter whenever a blur request is taken. Every read and blur
// result is compared against it in order.
// ----------------------------------------------------------------------------
module tb_exponential_blur_2d_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import exb2d_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int STORE_DIM = 256;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] pix;
    } blur_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           req_type = REQ_WRITE;
    logic [IDX_W-1:0]     col_index = '0;
    logic [IDX_W-1:0]     row_index = '0;
    logic [PIX_W-1:0]     pixel_in = '0;
    logic                 result_valid;
    logic [PIX_W-1:0]     pixel_out;
    logic                 blur_done;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Local image and register copies.
    logic [PIX_W-1:0]     image_mem [0:STORE_DIM*STORE_DIM-1];
    bit                   pixel_written [0:STORE_DIM*STORE_DIM-1];
    int                   written_addrs [$];
    logic [ALPHA_W-1:0]   alpha_q16 = '0;
    logic                 enable_q = 1'b0;
    logic [CFG_DIM_W-1:0] width_q = DIM_RESET;
    logic [CFG_DIM_W-1:0] height_q = DIM_RESET;

    blur_result_t         outstanding_results [$];
    blur_result_t         oldest_result;
    int                   idle_pct = 19;
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   n_writes = 0;
    int                   n_reads = 0;
    int                   n_blurs = 0;
    int                   n_ignored = 0;
    int                   n_settings = 0;

    exponential_blur_2d_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .col_index    (col_index),
        .row_index    (row_index),
        .pixel_in     (pixel_in),
        .result_valid (result_valid),
        .pixel_out    (pixel_out),
        .blur_done    (blur_done),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("exponential_blur_2d_unit verification failed");
            $finish;
        end
    end

    // Results cannot be stalled, so every strobe is matched at once.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (outstanding_results.size() == 0)
            begin
                $error("result with no pending request: pixel_out %0d blur_done %0d",
                       pixel_out, blur_done);
                mismatch_count++;
            end
            else
            begin
                oldest_result = outstanding_results.pop_front();
                if (pixel_out !== oldest_result.pix)
                begin
                    $error("pixel_out mismatch: expected %0d, got %0d",
                           oldest_result.pix, pixel_out);
                    mismatch_count++;
                end
                if (blur_done !== oldest_result.done)
                begin
                    $error("blur_done mismatch: expected %0d, got %0d",
                           oldest_result.done, blur_done);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int region_width();
        return (width_q > STORE_DIM) ? STORE_DIM : int'(width_q);
    endfunction

    function automatic int region_height();
        return (height_q > STORE_DIM) ? STORE_DIM : int'(height_q);
    endfunction

    // One filter step; the shift of the signed product rounds toward minus infinity.
    function automatic logic [PIX_W-1:0] filter_step(inout int acc, input logic [PIX_W-1:0] p);
        longint diff;
        longint prod;
        diff = longint'(p) * 128 - longint'(acc);
        prod = longint'(alpha_q16) * diff;
        acc = acc + int'(prod >>> 16);
        return PIX_W'(acc >> 7);
    endfunction

    function automatic void smooth_line(input int base, input int stride, input int n);
        int acc;
        int k;
        acc = 0;
        for (k = 1; k < n; k++)
            image_mem[base + k*stride] = filter_step(acc, image_mem[base + k*stride]);
        image_mem[base + (n-1)*stride] = '0;
        acc = 0;
        for (k = n - 1; k > 0; k--)
            image_mem[base + (k-1)*stride] = filter_step(acc, image_mem[base + (k-1)*stride]);
        image_mem[base] = '0;
    endfunction

    function automatic void blur_image();
        int w;
        int h;
        int i;
        w = region_width();
        h = region_height();
        if (!enable_q || w == 0 || h == 0)
            return;
        for (i = 0; i < h; i++)
        begin
            smooth_line(i*STORE_DIM, 1, w);
            smooth_line(i*STORE_DIM, 1, w);
        end
        for (i = 0; i < w; i++)
        begin
            smooth_line(i, STORE_DIM, h);
            smooth_line(i, STORE_DIM, h);
        end
    endfunction

    task automatic send_request(input logic [1:0] kind, input logic [IDX_W-1:0] col,
                                input logic [IDX_W-1:0] row, input logic [PIX_W-1:0] pix);
        int gap;
        int addr;
        blur_result_t owed;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < idle_pct)
            gap++;
        start     <= 1'b1;
        req_type  <= kind;
        col_index <= col;
        row_index <= row;
        pixel_in  <= pix;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        addr = {row, col};
        case (kind)
            REQ_WRITE:
            begin
                image_mem[addr] = pix;
                if (!pixel_written[addr])
                begin
                    pixel_written[addr] = 1'b1;
                    written_addrs.push_back(addr);
                end
                n_writes++;
            end
            REQ_BLUR:
            begin
                blur_image();
                owed.done = 1'b1;
                owed.pix  = '0;
                outstanding_results.push_back(owed);
                n_blurs++;
            end
            REQ_READ:
            begin
                owed.done = 1'b0;
                owed.pix  = image_mem[addr];
                outstanding_results.push_back(owed);
                n_reads++;
            end
            default:
                n_ignored++;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic read_pixel(input int addr);
        send_request(REQ_READ, IDX_W'(addr), IDX_W'(addr >> 8), PIX_W'($urandom));
    endtask

    task automatic read_random_pixel();
        read_pixel(written_addrs[$urandom_range(written_addrs.size() - 1)]);
    endtask

    task automatic request_blur();
        send_request(REQ_BLUR, IDX_W'($urandom), IDX_W'($urandom), PIX_W'($urandom));
    endtask

    // A filtering blur must never pull in a pixel that was never written.
    task automatic fill_region();
        int r;
        int c;
        if (!enable_q)
            return;
        for (r = 0; r < region_height(); r++)
            for (c = 0; c < region_width(); c++)
                if (!pixel_written[r*STORE_DIM + c])
                    send_request(REQ_WRITE, IDX_W'(c), IDX_W'(r), PIX_W'($urandom));
    endtask

    // A write leaves no result behind, so a short pause follows the last one.
    task automatic drain_results();
        start <= 1'b0;
        while (outstanding_results.size() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_check(input logic [1:0] index, input logic [APB_DW-1:0] want,
                             input string field);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {index, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== want)
        begin
            $error("%s readback mismatch: expected %0d, got %0d", field, want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [ALPHA_W-1:0] alpha, input logic enable,
                              input logic [CFG_DIM_W-1:0] w, input logic [CFG_DIM_W-1:0] h);
        drain_results();
        apb_write(REG_ALPHA, APB_DW'(alpha));
        apb_write(REG_ENABLE, APB_DW'(enable));
        apb_write(REG_WIDTH, APB_DW'(w));
        apb_write(REG_HEIGHT, APB_DW'(h));
        alpha_q16 = alpha;
        enable_q  = enable;
        width_q   = w;
        height_q  = h;
        n_settings++;
    endtask

    task automatic test_register_file();
        apb_check(REG_ALPHA, '0, "blur_alpha");
        apb_check(REG_ENABLE, '0, "blur_enable");
        apb_check(REG_WIDTH, APB_DW'(DIM_RESET), "image_width");
        apb_check(REG_HEIGHT, APB_DW'(DIM_RESET), "image_height");
        // Upper bits beyond each register's width are dropped.
        apb_write(REG_ALPHA, 32'hFFFF_FFFF);
        apb_write(REG_ENABLE, 32'hFFFF_FFFF);
        apb_write(REG_WIDTH, 32'h0000_0155);
        apb_write(REG_HEIGHT, 32'h0000_00AA);
        apb_check(REG_ALPHA, 32'h0000_FFFF, "blur_alpha");
        apb_check(REG_ENABLE, 32'h0000_0001, "blur_enable");
        apb_check(REG_WIDTH, 32'h0000_0155, "image_width");
        apb_check(REG_HEIGHT, 32'h0000_00AA, "image_height");
    endtask

    task automatic test_pixel_store();
        set_config(16'd0, 1'b0, DIM_RESET, DIM_RESET);
        send_request(REQ_WRITE, 8'd0, 8'd0, 8'd0);
        send_request(REQ_WRITE, 8'd255, 8'd255, 8'd255);
        send_request(REQ_WRITE, 8'd0, 8'd255, 8'hAA);
        send_request(REQ_WRITE, 8'd255, 8'd0, 8'h55);
        read_pixel(0);
        read_pixel(16'hFFFF);
        read_pixel(16'hFF00);
        read_pixel(16'h00FF);
        // An unknown request code must not produce a result.
        send_request(REQ_UNUSED, 8'd7, 8'd7, 8'd1);
        send_request(REQ_WRITE, 8'd0, 8'd0, 8'h80);
        read_pixel(0);
        // With the filter disabled the image must come through untouched.
        request_blur();
        read_pixel(16'hFFFF);
        read_pixel(16'hFF00);
    endtask

    task automatic test_blur_directed();
        logic [PIX_W-1:0] seed_pix [0:5];
        int k;
        seed_pix = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128};
        set_config(16'hFFFF, 1'b1, 9'd3, 9'd2);
        for (k = 0; k < 6; k++)
            send_request(REQ_WRITE, IDX_W'(k % 3), IDX_W'(k / 3), seed_pix[k]);
        request_blur();
        for (k = 0; k < 6; k++)
            read_pixel((k / 3)*STORE_DIM + k % 3);
        set_config(16'd0, 1'b1, 9'd3, 9'd2);
        request_blur();
        read_pixel(1);
        // Empty regions still acknowledge the blur.
        set_config(16'd1234, 1'b1, 9'd0, 9'd4);
        request_blur();
        set_config(16'd1234, 1'b1, 9'd4, 9'd0);
        request_blur();
        read_pixel(2);
        set_config(16'd30000, 1'b1, 9'd1, 9'd1);
        request_blur();
        read_pixel(0);
    endtask

    task automatic test_region_extremes();
        int k;
        // Oversized dimensions are clipped to the store size.
        set_config(16'd20000, 1'b1, 9'd511, 9'd1);
        fill_region();
        request_blur();
        for (k = 0; k < 6; k++)
            read_pixel($urandom_range(STORE_DIM - 1));
        read_pixel(STORE_DIM - 1);
        set_config(16'd45000, 1'b1, 9'd1, 9'd300);
        fill_region();
        request_blur();
        for (k = 0; k < 6; k++)
            read_pixel($urandom_range(STORE_DIM - 1) * STORE_DIM);
        read_pixel((STORE_DIM - 1) * STORE_DIM);
    endtask

    task automatic test_random_traffic(input int epochs, input int per_epoch);
        int e;
        int n;
        int pick;
        logic [ALPHA_W-1:0] alpha;
        logic [CFG_DIM_W-1:0] w;
        logic [CFG_DIM_W-1:0] h;
        for (e = 0; e < epochs; e++)
        begin
            case ($urandom_range(3))
                0: alpha = '0;
                1: alpha = '1;
                2: alpha = ALPHA_W'($urandom_range(1, 8000));
                default: alpha = ALPHA_W'($urandom);
            endcase
            if ($urandom_range(11) == 0)
            begin
                w = CFG_DIM_W'($urandom_range(257, 511));
                h = CFG_DIM_W'($urandom_range(0, 1));
            end
            else
            begin
                w = CFG_DIM_W'($urandom_range(0, 9));
                h = CFG_DIM_W'($urandom_range(0, 9));
            end
            set_config(alpha, $urandom_range(5) != 0, w, h);
            n = 0;
            while (n < per_epoch)
            begin
                pick = $urandom_range(99);
                if (pick < 45 && region_width() > 0 && region_height() > 0)
                    send_request(REQ_WRITE, IDX_W'($urandom_range(region_width() - 1)),
                                 IDX_W'($urandom_range(region_height() - 1)),
                                 PIX_W'($urandom));
                else if (pick < 55)
                    send_request(REQ_WRITE, IDX_W'($urandom), IDX_W'($urandom),
                                 PIX_W'($urandom));
                else if (pick < 82)
                    read_random_pixel();
                else if (pick < 93)
                begin
                    fill_region();
                    request_blur();
                end
                else
                begin
                    send_request(REQ_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                                 PIX_W'($urandom));
                    n--;
                end
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_pct = 19;
        test_register_file();
        test_pixel_store();
        test_blur_directed();
        test_region_extremes();
        test_random_traffic(6, 10);
        idle_pct = 79;
        test_random_traffic(6, 10);
        idle_pct = 0;
        test_random_traffic(6, 10);
        drain_results();
        $display("Run covered %0d pixel writes, %0d reads, %0d blur requests and %0d ignored",
                 n_writes, n_reads, n_blurs, n_ignored);
        $display("requests over %0d register settings, in %0d cycles.", n_settings, cycle_count);
        if (mismatch_count == 0)
            $display("exponential_blur_2d_unit verification clean");
        else
            $display("exponential_blur_2d_unit verification failed");
        $finish;
    end

endmodule
